// ===== design/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic B-spline sampler package
// Shared types and widths for the cubic B-spline curve sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int CoordWidth  = 11;
   localparam int IndexWidth  = 6;
   localparam int WeightWidth = 16;
   localparam int ProdWidth   = WeightWidth + CoordWidth;
   localparam int AccWidth    = ProdWidth + 1;
   localparam int Taps        = 4;
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 32;
   localparam logic [AccWidth-1:0] RoundHalf = AccWidth'(1) << (WeightWidth - 1);

   typedef logic [CoordWidth-1:0]  coord_type;
   typedef logic [IndexWidth-1:0]  index_type;
   typedef logic [WeightWidth-1:0] weight_type;
   typedef logic [ProdWidth-1:0]   prod_type;
   typedef logic [AccWidth-1:0]    acc_type;

   typedef struct packed {
      coord_type [Taps-1:0] x;
      coord_type [Taps-1:0] y;
   } quad_type;

   typedef struct packed {
      logic                  valid;
      quad_type              pts;
      weight_type [Taps-1:0] w;
      index_type             index;
      logic                  last;
   } sample_type;

endpackage

// ===== design/cbs_window.sv =====
// ----------------------------------------------------------------------------
// Control point window
// Holds the last three control points of the current curve and forms the
// four-point set whenever a new point completes one.
// ----------------------------------------------------------------------------
module cbs_window #(
   parameter int COORD_BITS = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  cbs_pkg::coord_type point_x,
   input  cbs_pkg::coord_type point_y,
   input  logic               curve_start,
   output logic               job_start,
   output cbs_pkg::quad_type  job
);

   localparam cbs_pkg::coord_type CoordMask =
      cbs_pkg::coord_type'((32'd1 << COORD_BITS) - 32'd1);

   logic [1:0]         held_ff, held_in, held_now;
   cbs_pkg::coord_type win_x_ff [3];
   cbs_pkg::coord_type win_y_ff [3];
   cbs_pkg::coord_type px, py;

   assign px       = point_x & CoordMask;
   assign py       = point_y & CoordMask;
   assign held_now = curve_start ? 2'd0 : held_ff;
   assign job_start = load && (held_now == 2'd3);

   always_comb begin
      job.x = {px, win_x_ff[2], win_x_ff[1], win_x_ff[0]};
      job.y = {py, win_y_ff[2], win_y_ff[1], win_y_ff[0]};
      held_in = (held_now == 2'd3) ? 2'd3 : held_now + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
      end else if (load) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (held_now == 2'd3) begin
            win_x_ff[0] <= win_x_ff[1];
            win_y_ff[0] <= win_y_ff[1];
            win_x_ff[1] <= win_x_ff[2];
            win_y_ff[1] <= win_y_ff[2];
            win_x_ff[2] <= px;
            win_y_ff[2] <= py;
         end else begin
            win_x_ff[held_now] <= px;
            win_y_ff[held_now] <= py;
         end
      end
   end

endmodule

// ===== design/cbs_issue.sv =====
// ----------------------------------------------------------------------------
// Sample issue stage
// Holds the current four-point set and steps the parameter index through the
// samples of one segment, looking up the basis weights for each.
// ----------------------------------------------------------------------------
module cbs_issue #(
   parameter int SAMPLES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                job_start,
   input  cbs_pkg::quad_type   job,
   output logic                can_load,
   output cbs_pkg::sample_type sample
);

   localparam int IdxBits = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(SAMPLES - 1);

   cbs_pkg::weight_type [cbs_pkg::Taps-1:0] weight_table [SAMPLES];

   for (genvar g = 0; g < SAMPLES; g++) begin : g_weight
      localparam longint unsigned D   = SAMPLES;
      localparam longint unsigned A   = g;
      localparam longint unsigned Den = 6 * D * D * D;
      localparam longint unsigned Da  = D - A;
      localparam longint unsigned N2  = 3 * A * A * D + 3 * A * D * D + D * D * D
                                        - 3 * A * A * A;
      localparam longint unsigned W0 = (Da * Da * Da * 131072 + Den) / (Den * 2);
      localparam longint unsigned W2 = (N2 * 131072 + Den) / (Den * 2);
      localparam longint unsigned W3 = (A * A * A * 131072 + Den) / (Den * 2);
      localparam longint unsigned W1 = 65536 - W0 - W2 - W3;
      assign weight_table[g] = {W3[15:0], W2[15:0], W1[15:0], W0[15:0]};
   end

   logic               busy_ff;
   logic [IdxBits-1:0] idx_ff;
   cbs_pkg::quad_type  quad_ff;
   logic               at_last;

   assign at_last  = (idx_ff == LastIdx);
   assign can_load = !busy_ff || at_last;

   always_comb begin
      sample.valid = busy_ff;
      sample.pts   = quad_ff;
      sample.w     = weight_table[idx_ff];
      sample.index = cbs_pkg::index_type'(idx_ff);
      sample.last  = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (advance) begin
         if (job_start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff && at_last) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + IdxBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && job_start) begin
         quad_ff <= job;
      end
   end

endmodule

// ===== design/cbs_blend.sv =====
// ----------------------------------------------------------------------------
// Weighted blend
// Multiplies the four points by their weights in one stage, then sums,
// rounds and registers the curve point in the result stage.
// ----------------------------------------------------------------------------
module cbs_blend (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  cbs_pkg::sample_type sample,
   output logic                out_valid,
   output cbs_pkg::coord_type  curve_x,
   output cbs_pkg::coord_type  curve_y,
   output cbs_pkg::index_type  sample_index,
   output logic                last_sample
);

   logic                 prod_valid_ff;
   cbs_pkg::prod_type    prod_x_ff [cbs_pkg::Taps];
   cbs_pkg::prod_type    prod_y_ff [cbs_pkg::Taps];
   cbs_pkg::index_type   prod_index_ff;
   logic                 prod_last_ff;

   logic                 out_valid_ff;
   cbs_pkg::coord_type   out_x_ff, out_y_ff;
   cbs_pkg::index_type   out_index_ff;
   logic                 out_last_ff;

   cbs_pkg::acc_type     acc_x, acc_y;

   always_comb begin
      acc_x = cbs_pkg::RoundHalf;
      acc_y = cbs_pkg::RoundHalf;
      for (int k = 0; k < cbs_pkg::Taps; k++) begin
         acc_x = acc_x + cbs_pkg::acc_type'(prod_x_ff[k]);
         acc_y = acc_y + cbs_pkg::acc_type'(prod_y_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= sample.valid;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < cbs_pkg::Taps; k++) begin
            prod_x_ff[k] <= cbs_pkg::prod_type'(sample.w[k])
                            * cbs_pkg::prod_type'(sample.pts.x[k]);
            prod_y_ff[k] <= cbs_pkg::prod_type'(sample.w[k])
                            * cbs_pkg::prod_type'(sample.pts.y[k]);
         end
         prod_index_ff <= sample.index;
         prod_last_ff  <= sample.last;
         out_x_ff      <= acc_x[cbs_pkg::WeightWidth +: cbs_pkg::CoordWidth];
         out_y_ff      <= acc_y[cbs_pkg::WeightWidth +: cbs_pkg::CoordWidth];
         out_index_ff  <= prod_index_ff;
         out_last_ff   <= prod_last_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign curve_x      = out_x_ff;
   assign curve_y      = out_y_ff;
   assign sample_index = out_index_ff;
   assign last_sample  = out_last_ff;

endmodule

// ===== design/cubic_bspline_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// Cubic B-spline curve sampler
// Samples a uniform cubic B-spline through a stream of 2-D control points.
// ----------------------------------------------------------------------------
// Control points arrive on the req_ channel, one per transfer; req_tuser set
// marks the first point of a new curve and empties the window. The first
// three points of a curve are only stored and produce nothing. Each further
// point produces SAMPLES curve points on the rsp_ channel, one per cycle
// unless rsp_tready stalls, with rsp_tlast on the final one.
// The first result of a point passes the issue, product and result registers.
// Points that produce results are taken as the issue stage's sample counter
// allows; stored-only points are taken every cycle while the issue stage is
// idle and no result stalls. While it issues, the next point is taken in the
// cycle in which it presents its last sample, so results stream without gaps.
// Reset empties the window and the pipeline. While a result waits with
// rsp_tready low, the whole pipeline holds, the result stays on rsp_tdata
// and req_tready is low.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_sampler #(
   parameter int SAMPLES    = 8,
   parameter int COORD_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cbs_pkg::ReqDataWidth-1:0]  req_tdata,   // point_x[10:0], point_y[21:11]
   input  logic                              req_tuser,   // curve_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbs_pkg::RspDataWidth-1:0]  rsp_tdata,
   // curve_x[10:0], curve_y[21:11], sample_index[27:22]
   output logic                              rsp_tlast
);

   logic                advance;
   logic                can_load;
   logic                load;
   logic                job_start;
   cbs_pkg::quad_type   job;
   cbs_pkg::sample_type sample;
   cbs_pkg::coord_type  curve_x, curve_y;
   cbs_pkg::index_type  sample_index;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance && can_load;
   assign load       = req_tvalid && req_tready;

   cbs_window #(
      .COORD_BITS(COORD_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .point_x    (req_tdata[10:0]),
      .point_y    (req_tdata[21:11]),
      .curve_start(req_tuser),
      .job_start  (job_start),
      .job        (job)
   );

   cbs_issue #(
      .SAMPLES(SAMPLES)
   ) u_issue (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .job_start(job_start),
      .job      (job),
      .can_load (can_load),
      .sample   (sample)
   );

   cbs_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .sample      (sample),
      .out_valid   (rsp_tvalid),
      .curve_x     (curve_x),
      .curve_y     (curve_y),
      .sample_index(sample_index),
      .last_sample (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, sample_index, curve_y, curve_x};

endmodule

// ===== design/cbs_checker.sv =====
// ----------------------------------------------------------------------------
// Cubic B-spline sampler checker
// Port-level properties of the curve sampler, bound to the top level.
// ----------------------------------------------------------------------------
module cbs_checker #(
   parameter int SAMPLES    = 8,
   parameter int COORD_BITS = 11
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   localparam logic [5:0] LastIndex = 6'(SAMPLES - 1);

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_last_marks_end : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[27:22] == LastIndex)))
      else $error("last flag does not match the final sample index");

   a_index_steps : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[27:22] == 6'($past(rsp_tdata[27:22]) + 6'd1)))
      else $error("sample index did not step within a segment");

   a_coord_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[10:0] >> COORD_BITS) == 11'd0)
                  && ((rsp_tdata[21:11] >> COORD_BITS) == 11'd0))
      else $error("curve coordinate beyond the coordinate width");

endmodule

bind cubic_bspline_curve_sampler cbs_checker #(
   .SAMPLES   (SAMPLES),
   .COORD_BITS(COORD_BITS)
) u_cbs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

// ===== tb/cubic_bspline_curve_sampler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic B-spline curve sampler testbench
// Sends control points over the request stream and compares every curve
// sample against a behavioural model of the spline window, with random
// idling on both streams, a long result stall and a drain pause.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_sampler_tb;

   localparam int SAMPLE_COUNT = 8;
   localparam int COORD_MAX    = 2047;

   typedef struct {
      cbs_pkg::coord_type x;
      cbs_pkg::coord_type y;
      logic               start;
      int unsigned        gap;
      bit                 drain_first;
   } control_point_type;

   typedef struct {
      cbs_pkg::coord_type x;
      cbs_pkg::coord_type y;
      cbs_pkg::index_type index;
      logic               last;
   } curve_sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // point_x[10:0], point_y[21:11]
   logic        req_tuser = 1'b0; // curve_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // curve_x[10:0], curve_y[21:11], sample_index[27:22]
   logic        rsp_tlast;

   control_point_type point_queue[$];
   curve_sample_type  sample_queue[$];

   int unsigned        basis[SAMPLE_COUNT][4];
   cbs_pkg::coord_type held_x[3];
   cbs_pkg::coord_type held_y[3];
   int unsigned        held_count = 0;

   int unsigned accepted_points = 0;
   int unsigned mismatch_count = 0;
   int unsigned gap_left = 0;
   bit          gap_loaded = 1'b0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;
   logic        long_hold = 1'b0;

   cubic_bspline_curve_sampler #(
      .SAMPLES    (SAMPLE_COUNT),
      .COORD_BITS (cbs_pkg::CoordWidth)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned q16_round(longint unsigned num);
      longint unsigned den;
      den = 6 * SAMPLE_COUNT * SAMPLE_COUNT * SAMPLE_COUNT;
      return (num * 65536 * 2 + den) / (den * 2);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic cbs_pkg::coord_type pick_coord();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return cbs_pkg::coord_type'(COORD_MAX);
      return cbs_pkg::coord_type'($urandom_range(0, COORD_MAX));
   endfunction

   task automatic add_point(int unsigned x, int unsigned y, logic start,
                            int unsigned gap, bit drain_first);
      control_point_type p;
      p.x = cbs_pkg::coord_type'(x);
      p.y = cbs_pkg::coord_type'(y);
      p.start = start;
      p.gap = gap;
      p.drain_first = drain_first;
      point_queue.push_back(p);
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // Works out the samples that one accepted control point causes.
   task automatic predict_samples(control_point_type p);
      longint unsigned    acc_x;
      longint unsigned    acc_y;
      cbs_pkg::coord_type qx[4];
      cbs_pkg::coord_type qy[4];
      curve_sample_type   s;
      if (p.start) held_count = 0;
      if (held_count < 3) begin
         held_x[held_count] = p.x;
         held_y[held_count] = p.y;
         held_count++;
      end else begin
         for (int k = 0; k < 3; k++) begin
            qx[k] = held_x[k];
            qy[k] = held_y[k];
         end
         qx[3] = p.x;
         qy[3] = p.y;
         for (int i = 0; i < SAMPLE_COUNT; i++) begin
            acc_x = 32768;
            acc_y = 32768;
            for (int k = 0; k < 4; k++) begin
               acc_x += longint'(basis[i][k]) * qx[k];
               acc_y += longint'(basis[i][k]) * qy[k];
            end
            s.x = cbs_pkg::coord_type'(acc_x >> 16);
            s.y = cbs_pkg::coord_type'(acc_y >> 16);
            s.index = cbs_pkg::index_type'(i);
            s.last = (i == SAMPLE_COUNT - 1);
            sample_queue.push_back(s);
         end
         held_x[0] = held_x[1];
         held_y[0] = held_y[1];
         held_x[1] = held_x[2];
         held_y[1] = held_y[2];
         held_x[2] = p.x;
         held_y[2] = p.y;
      end
   endtask

   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         gap_loaded = 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_samples(point_queue.pop_front());
            accepted_points++;
            gap_loaded = 1'b0;
            offer = 1'b0;
         end
         if (!offer && point_queue.size() != 0) begin
            if (!gap_loaded) begin
               gap_left = point_queue[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            end else if (!(point_queue[0].drain_first && sample_queue.size() != 0)) begin
               offer = 1'b1;
               req_tdata <= {2'b00, point_queue[0].y, point_queue[0].x};
               req_tuser <= point_queue[0].start;
            end
         end
         req_tvalid <= offer;
      end
   end

   always @(posedge clock) begin
      logic             ready;
      curve_sample_type s;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         calm_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sample_queue.size() == 0) begin
               report_mismatch("sample transfer with none pending, curve_x",
                               32'(rsp_tdata[10:0]), 32'd0);
            end else begin
               s = sample_queue.pop_front();
               if (rsp_tdata[10:0] !== s.x)
                  report_mismatch("curve_x", 32'(rsp_tdata[10:0]), 32'(s.x));
               if (rsp_tdata[21:11] !== s.y)
                  report_mismatch("curve_y", 32'(rsp_tdata[21:11]), 32'(s.y));
               if (rsp_tdata[27:22] !== s.index)
                  report_mismatch("sample_index", 32'(rsp_tdata[27:22]), 32'(s.index));
               if (rsp_tlast !== s.last)
                  report_mismatch("last_sample", 32'(rsp_tlast), 32'(s.last));
            end
         end
         if (long_hold) begin
            ready = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            ready = 1'b0;
         end else if (calm_left != 0) begin
            calm_left--;
            ready = 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(20, 80);
            ready = 1'b1;
         end else begin
            stall_left = pick_gap();
            ready = (stall_left == 0);
            if (stall_left != 0) stall_left--;
         end
         rsp_tready <= ready;
      end
   end

   // The result side holds off for a long stretch while points keep coming.
   initial begin
      while (accepted_points < 60) @(posedge clock);
      long_hold <= 1'b1;
      repeat (400) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("cubic_bspline_curve_sampler: mismatch");
      $finish;
   end

   initial begin
      int unsigned     random_points;
      int unsigned     curve_len;
      bit              calm;
      longint unsigned d;
      longint unsigned a;
      d = SAMPLE_COUNT;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         a = i;
         basis[i][0] = 32'(q16_round((d - a) * (d - a) * (d - a)));
         basis[i][2] = 32'(q16_round(3 * a * a * d + 3 * a * d * d + d * d * d
                                     - 3 * a * a * a));
         basis[i][3] = 32'(q16_round(a * a * a));
         basis[i][1] = 65536 - basis[i][0] - basis[i][2] - basis[i][3];
      end

      // The window starts empty after reset, without any curve start.
      add_point(0, 0, 1'b0, 0, 1'b0);
      add_point(COORD_MAX, COORD_MAX, 1'b0, 0, 1'b0);
      add_point(0, COORD_MAX, 1'b0, 0, 1'b0);
      add_point(COORD_MAX, 0, 1'b0, 0, 1'b0);
      add_point(1365, 682, 1'b0, 0, 1'b0);
      // A curve of full-scale points must stay at full scale.
      add_point(COORD_MAX, COORD_MAX, 1'b1, 2, 1'b0);
      add_point(COORD_MAX, COORD_MAX, 1'b0, 0, 1'b0);
      add_point(COORD_MAX, COORD_MAX, 1'b0, 0, 1'b0);
      add_point(COORD_MAX, COORD_MAX, 1'b0, 0, 1'b0);
      add_point(0, 0, 1'b0, 0, 1'b0);
      add_point(682, 1365, 1'b0, 0, 1'b0);
      // Curve starts with a full window and with a partly filled one.
      add_point(0, 0, 1'b1, 0, 1'b1);
      add_point(0, 0, 1'b0, 0, 1'b0);
      add_point(5, 9, 1'b1, 0, 1'b0);
      add_point(1365, 682, 1'b0, 0, 1'b0);
      add_point(682, 1365, 1'b0, 0, 1'b0);
      add_point(1, 2046, 1'b0, 0, 1'b0);
      add_point(2046, 1, 1'b0, 0, 1'b0);
      add_point(1024, 1023, 1'b1, 0, 1'b0);
      add_point(1023, 1024, 1'b0, 0, 1'b0);
      add_point(1024, 1023, 1'b0, 0, 1'b0);
      add_point(0, 0, 1'b0, 0, 1'b0);
      add_point(COORD_MAX, 0, 1'b0, 0, 1'b0);

      random_points = 0;
      while (random_points < 245) begin
         curve_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 16);
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < curve_len; n++) begin
            add_point(pick_coord(), pick_coord(),
                      (n == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0),
                      calm ? 0 : pick_gap(),
                      (random_points == 0) || ($urandom_range(0, 59) == 0));
            random_points++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (point_queue.size() != 0) @(posedge clock);
      while (sample_queue.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("cubic_bspline_curve_sampler: match");
      end else begin
         $display("cubic_bspline_curve_sampler: mismatch");
      end
      $finish;
   end

endmodule
